// ===== rtl/core/lpbev_pkg.sv =====
// shared constants for the bird's-eye lidar pixel painter
`timescale 1ns / 1ps
package lpbev_pkg;

  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned REG_W     = 24;
  localparam int unsigned COORD_W   = 18;
  localparam int unsigned INTEN_W   = 8;
  localparam int unsigned INDEX_W   = 17;
  localparam int unsigned COLOR_W   = 8;
  localparam int unsigned MASK_W    = 3;
  localparam int unsigned FRAC_W    = 24;

  localparam logic [CFG_IDX_W-1:0] REG_PIXELS_PER_MM  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INV_HEIGHT     = 2'd1;

  localparam logic [REG_W-1:0] PIXELS_PER_MM_RST = 24'd335544;
  localparam logic [REG_W-1:0] INV_HEIGHT_RST    = 24'd33554;

  localparam logic [MASK_W-1:0] MASK_ABOVE = 3'b011;
  localparam logic [MASK_W-1:0] MASK_BELOW = 3'b110;

  localparam logic [9:0] INTEN_BASE = 10'd360;

endpackage

// ===== rtl/core/lidar_point_bev_pixel_painter.sv =====
// top level of the bird's-eye lidar pixel painter, a four-stage pipeline
`timescale 1ns / 1ps
// Maps each lidar point request to one masked pixel write on a square canvas of
// CANVAS_SIZE pixels a side. One request is taken per clock while the output is not
// stalled; results leave in order. The pipeline has four register stages:
// the three 18x25 multipliers for x, y and z, the truncating coordinate shift
// with the bounds check and height clamp, the weight and pixel index forming, and
// the two 25x10 colour multipliers with saturation feeding the output register.
// A stalled output only backs up the stages that are full; no request is lost.
// Registers written over the cfg port take effect for requests taken afterwards.
module lidar_point_bev_pixel_painter #(
  parameter int unsigned CANVAS_SIZE = 320
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [lpbev_pkg::COORD_W-1:0] in_x_mm,
  input  logic signed [lpbev_pkg::COORD_W-1:0] in_y_mm,
  input  logic signed [lpbev_pkg::COORD_W-1:0] in_z_mm,
  input  logic [lpbev_pkg::INTEN_W-1:0]       in_intensity,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_in_canvas,
  output logic [lpbev_pkg::INDEX_W-1:0]       out_pixel_index,
  output logic [lpbev_pkg::COLOR_W-1:0]       out_blue,
  output logic [lpbev_pkg::COLOR_W-1:0]       out_green,
  output logic [lpbev_pkg::COLOR_W-1:0]       out_red,
  output logic [lpbev_pkg::MASK_W-1:0]        out_write_mask,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [lpbev_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lpbev_pkg::REG_W-1:0]         cfg_data
);

  localparam int unsigned CW     = $clog2(CANVAS_SIZE);
  localparam int unsigned PW     = (2 * CW + 1 > lpbev_pkg::INDEX_W) ? 2 * CW + 1
                                                                     : lpbev_pkg::INDEX_W;
  localparam int unsigned PROD_W = 43;
  localparam int unsigned V_W    = 44;
  localparam int unsigned PIX_W  = V_W - lpbev_pkg::FRAC_W;
  localparam int unsigned H_W    = lpbev_pkg::FRAC_W + 2;
  localparam int unsigned WT_W   = lpbev_pkg::FRAC_W + 1;
  localparam int unsigned CP_W   = WT_W + 10;

  localparam logic signed [V_W-1:0]   CENTER_Q = V_W'(CANVAS_SIZE / 2) <<< lpbev_pkg::FRAC_W;
  localparam logic signed [H_W-1:0]   H_MAX    = H_W'(1) <<< lpbev_pkg::FRAC_W;
  localparam logic signed [H_W-1:0]   H_MIN    = -H_MAX;
  localparam logic [WT_W-1:0]         ONE_Q    = WT_W'(1) << lpbev_pkg::FRAC_W;
  localparam logic [PIX_W-2:0]        CS_LIM   = (PIX_W-1)'(CANVAS_SIZE);
  localparam logic [PW-1:0]           CS_P     = PW'(CANVAS_SIZE);

  // configuration registers
  logic [lpbev_pkg::REG_W-1:0] ppm_r;
  logic [lpbev_pkg::REG_W-1:0] inv_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ppm_r <= lpbev_pkg::PIXELS_PER_MM_RST;
      inv_r <= lpbev_pkg::INV_HEIGHT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        lpbev_pkg::REG_PIXELS_PER_MM: ppm_r <= cfg_data;
        lpbev_pkg::REG_INV_HEIGHT:    inv_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // handshake chain
  logic v1_r, v2_r, v3_r, v4_r;
  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy4     = !v4_r || out_ready;
  assign rdy3     = !v3_r || rdy4;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
    end
  end

  // stage 1: scale products
  logic signed [PROD_W-1:0] px_nxt, py_nxt, pz_nxt;
  logic signed [PROD_W-1:0] px_r, py_r, pz_r;
  logic [9:0]               s1_r;

  assign px_nxt = in_x_mm * $signed({1'b0, ppm_r});
  assign py_nxt = in_y_mm * $signed({1'b0, ppm_r});
  assign pz_nxt = in_z_mm * $signed({1'b0, inv_r});

  always_ff @(posedge clk) begin
    if (rdy1) begin
      px_r <= px_nxt;
      py_r <= py_nxt;
      pz_r <= pz_nxt;
      s1_r <= lpbev_pkg::INTEN_BASE + 10'(in_intensity);
    end
  end

  // stage 2: truncating shift, bounds check, height clamp
  logic signed [V_W-1:0]   vx, vy;
  logic signed [PIX_W-1:0] rowp, colp;
  logic                    inside_nxt;
  logic signed [H_W-1:0]   h_nxt;
  logic [CW-1:0]           row_r, col_r;
  logic                    inside2_r;
  logic signed [H_W-1:0]   h_r;
  logic [9:0]              s2_r;

  assign vx   = CENTER_Q - V_W'(px_r);
  assign vy   = CENTER_Q - V_W'(py_r);
  assign rowp = vx[V_W-1:lpbev_pkg::FRAC_W]
              + PIX_W'(vx[V_W-1] && (|vx[lpbev_pkg::FRAC_W-1:0]));
  assign colp = vy[V_W-1:lpbev_pkg::FRAC_W]
              + PIX_W'(vy[V_W-1] && (|vy[lpbev_pkg::FRAC_W-1:0]));
  assign inside_nxt = !rowp[PIX_W-1] && (rowp[PIX_W-2:0] < CS_LIM)
                   && !colp[PIX_W-1] && (colp[PIX_W-2:0] < CS_LIM);

  always_comb begin
    priority if (pz_r > PROD_W'(H_MAX)) begin
      h_nxt = H_MAX;
    end else if (pz_r < PROD_W'(H_MIN)) begin
      h_nxt = H_MIN;
    end else begin
      h_nxt = pz_r[H_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      row_r     <= rowp[CW-1:0];
      col_r     <= colp[CW-1:0];
      inside2_r <= inside_nxt;
      h_r       <= h_nxt;
      s2_r      <= s1_r;
    end
  end

  // stage 3: colour weights and pixel index
  logic              pos_nxt;
  logic [WT_W-1:0]   wa_nxt, wg_nxt;
  logic [PW-1:0]     idx_nxt;
  logic              pos_r, inside3_r;
  logic [WT_W-1:0]   wa_r, wg_r;
  logic [lpbev_pkg::INDEX_W-1:0] idx_r;
  logic [9:0]        s3_r;

  assign pos_nxt = !h_r[H_W-1] && (|h_r);
  assign wa_nxt  = pos_nxt ? h_r[WT_W-1:0] : WT_W'(-h_r);
  assign wg_nxt  = pos_nxt ? ONE_Q - h_r[WT_W-1:0] : ONE_Q + h_r[WT_W-1:0];
  assign idx_nxt = PW'(row_r) * CS_P + PW'(col_r);

  always_ff @(posedge clk) begin
    if (rdy3) begin
      pos_r     <= pos_nxt;
      inside3_r <= inside2_r;
      wa_r      <= wa_nxt;
      wg_r      <= wg_nxt;
      idx_r     <= idx_nxt[lpbev_pkg::INDEX_W-1:0];
      s3_r      <= s2_r;
    end
  end

  // stage 4: colour products, saturation, output register
  logic [CP_W-1:0] pa, pg;
  logic [9:0]      ca, cg;
  logic [lpbev_pkg::COLOR_W-1:0] sa, sg;
  logic                          inc_r;
  logic [lpbev_pkg::INDEX_W-1:0] idx4_r;
  logic [lpbev_pkg::COLOR_W-1:0] blue_r, green_r, red_r;
  logic [lpbev_pkg::MASK_W-1:0]  mask_r;

  assign pa = CP_W'(wa_r) * CP_W'(s3_r);
  assign pg = CP_W'(wg_r) * CP_W'(s3_r);
  assign ca = pa[CP_W-1:lpbev_pkg::FRAC_W+1];
  assign cg = pg[CP_W-1:lpbev_pkg::FRAC_W+1];
  assign sa = (|ca[9:8]) ? 8'hFF : ca[7:0];
  assign sg = (|cg[9:8]) ? 8'hFF : cg[7:0];

  always_ff @(posedge clk) begin
    if (rdy4) begin
      inc_r   <= inside3_r;
      idx4_r  <= inside3_r ? idx_r : '0;
      blue_r  <= (inside3_r && pos_r) ? sa : '0;
      red_r   <= (inside3_r && !pos_r) ? sa : '0;
      green_r <= inside3_r ? sg : '0;
      mask_r  <= !inside3_r ? '0 : (pos_r ? lpbev_pkg::MASK_ABOVE : lpbev_pkg::MASK_BELOW);
    end
  end

  assign out_valid       = v4_r;
  assign out_in_canvas   = inc_r;
  assign out_pixel_index = idx4_r;
  assign out_blue        = blue_r;
  assign out_green       = green_r;
  assign out_red         = red_r;
  assign out_write_mask  = mask_r;

  // checks
  a_stall_only_on_output: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input stalled while output drains");

  a_outside_all_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_in_canvas) |->
      (out_write_mask == '0 && out_pixel_index == '0 && out_green == '0))
    else $error("outside write carries data");

  a_inside_mask: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_in_canvas) |->
      (out_write_mask == lpbev_pkg::MASK_ABOVE || out_write_mask == lpbev_pkg::MASK_BELOW))
    else $error("bad write mask");

  a_unmasked_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_write_mask[2] || out_red == '0) && (out_write_mask[0] || out_blue == '0)))
    else $error("unmasked colour not zero");

  a_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (v3_r && rdy4) |=> v4_r)
    else $error("item lost between stage three and output");

endmodule

// ===== dv/lidar_point_bev_pixel_painter_tb.sv =====
// self-checking testbench for the bird's-eye lidar pixel painter
`timescale 1ns / 1ps
module lidar_point_bev_pixel_painter_tb;

  localparam int CANVAS = 320;
  localparam int RST_CYCLES = 6;
  localparam int IDLE_PCT = 19;
  localparam int HOLD_CYCLES = 60;
  localparam int DRAIN_CYCLES = 8;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam longint COORD_MAX = 131071;
  localparam logic [lpbev_pkg::CFG_IDX_W-1:0] REG_UNMAPPED_2 = 2'd2;
  localparam logic [lpbev_pkg::CFG_IDX_W-1:0] REG_UNMAPPED_3 = 2'd3;

  typedef struct packed {
    logic                            in_canvas;
    logic [lpbev_pkg::INDEX_W-1:0]   pixel_index;
    logic [lpbev_pkg::COLOR_W-1:0]   blue;
    logic [lpbev_pkg::COLOR_W-1:0]   green;
    logic [lpbev_pkg::COLOR_W-1:0]   red;
    logic [lpbev_pkg::MASK_W-1:0]    write_mask;
  } pixel_write_t;

  logic                                 clk;
  logic                                 rst_n;
  logic                                 in_valid;
  logic                                 in_ready;
  logic signed [lpbev_pkg::COORD_W-1:0] in_x_mm;
  logic signed [lpbev_pkg::COORD_W-1:0] in_y_mm;
  logic signed [lpbev_pkg::COORD_W-1:0] in_z_mm;
  logic [lpbev_pkg::INTEN_W-1:0]        in_intensity;
  logic                                 out_valid;
  logic                                 out_ready;
  logic                                 out_in_canvas;
  logic [lpbev_pkg::INDEX_W-1:0]        out_pixel_index;
  logic [lpbev_pkg::COLOR_W-1:0]        out_blue;
  logic [lpbev_pkg::COLOR_W-1:0]        out_green;
  logic [lpbev_pkg::COLOR_W-1:0]        out_red;
  logic [lpbev_pkg::MASK_W-1:0]         out_write_mask;
  logic                                 cfg_valid;
  logic                                 cfg_ready;
  logic [lpbev_pkg::CFG_IDX_W-1:0]      cfg_index;
  logic [lpbev_pkg::REG_W-1:0]          cfg_data;

  logic [lpbev_pkg::REG_W-1:0] scale_ppm;
  logic [lpbev_pkg::REG_W-1:0] scale_inv_height;
  pixel_write_t     expected_writes[$];
  pixel_write_t     next_write;
  bit               idle_en;
  bit               hold_req;
  int               mismatches;
  int               points_sent;
  int               writes_checked;
  int               reg_writes;
  int               quiet_cycles;

  lidar_point_bev_pixel_painter #(.CANVAS_SIZE(CANVAS)) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_x_mm        (in_x_mm),
    .in_y_mm        (in_y_mm),
    .in_z_mm        (in_z_mm),
    .in_intensity   (in_intensity),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_in_canvas  (out_in_canvas),
    .out_pixel_index(out_pixel_index),
    .out_blue       (out_blue),
    .out_green      (out_green),
    .out_red        (out_red),
    .out_write_mask (out_write_mask),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint pixel_coord(input longint mm);
    longint v;
    v = longint'(CANVAS / 2) * (longint'(1) << lpbev_pkg::FRAC_W) - mm * longint'(scale_ppm);
    return v / (longint'(1) << lpbev_pkg::FRAC_W);
  endfunction

  function automatic logic [lpbev_pkg::COLOR_W-1:0] colour_sat(input longint weight,
                                                               input longint s);
    longint c;
    c = (weight * s) >>> (lpbev_pkg::FRAC_W + 1);
    return (c > 255) ? 8'hFF : c[lpbev_pkg::COLOR_W-1:0];
  endfunction

  function automatic pixel_write_t paint_point(input logic signed [lpbev_pkg::COORD_W-1:0] x,
                                               input logic signed [lpbev_pkg::COORD_W-1:0] y,
                                               input logic signed [lpbev_pkg::COORD_W-1:0] z,
                                               input logic [lpbev_pkg::INTEN_W-1:0] inten);
    pixel_write_t w;
    longint row, col, h, s, idx, one;
    one = longint'(1) << lpbev_pkg::FRAC_W;
    w = '0;
    col = pixel_coord(longint'(y));
    row = pixel_coord(longint'(x));
    if (col < 0 || col >= CANVAS || row < 0 || row >= CANVAS) return w;
    h = longint'(z) * longint'(scale_inv_height);
    if (h > one) h = one;
    if (h < -one) h = -one;
    s = longint'(lpbev_pkg::INTEN_BASE) + longint'(inten);
    idx = row * CANVAS + col;
    w.in_canvas = 1'b1;
    w.pixel_index = idx[lpbev_pkg::INDEX_W-1:0];
    if (h > 0) begin
      w.blue = colour_sat(h, s);
      w.green = colour_sat(one - h, s);
      w.write_mask = lpbev_pkg::MASK_ABOVE;
    end else begin
      w.green = colour_sat(one + h, s);
      w.red = colour_sat(-h, s);
      w.write_mask = lpbev_pkg::MASK_BELOW;
    end
    return w;
  endfunction

  function automatic longint coord_span(input logic [lpbev_pkg::REG_W-1:0] scale,
                                        input longint whole);
    longint span;
    if (scale == '0) return COORD_MAX;
    span = whole / longint'(scale) + 2;
    return (span > COORD_MAX) ? COORD_MAX : span;
  endfunction

  // mostly points near the canvas or the colour range, the rest anywhere
  function automatic logic signed [lpbev_pkg::COORD_W-1:0] pick_coord(input longint span);
    int offset;
    if ($urandom_range(99) < 80) begin
      offset = int'($urandom_range(2 * int'(span))) - int'(span);
      return offset[lpbev_pkg::COORD_W-1:0];
    end
    return lpbev_pkg::COORD_W'($urandom);
  endfunction

  function automatic logic [lpbev_pkg::REG_W-1:0] random_scale();
    return lpbev_pkg::REG_W'($urandom) >> $urandom_range(16);
  endfunction

  function automatic void check_field(input string field, input logic [31:0] want_v,
                                      input logic [31:0] got_v);
    if (want_v !== got_v) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want_v, got_v);
    end
  endfunction

  task automatic send_point(input logic signed [lpbev_pkg::COORD_W-1:0] x,
                            input logic signed [lpbev_pkg::COORD_W-1:0] y,
                            input logic signed [lpbev_pkg::COORD_W-1:0] z,
                            input logic [lpbev_pkg::INTEN_W-1:0] inten);
    if (idle_en && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < IDLE_PCT);
    end
    in_x_mm <= x;
    in_y_mm <= y;
    in_z_mm <= z;
    in_intensity <= inten;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    expected_writes.push_back(paint_point(x, y, z, inten));
    points_sent++;
    @(negedge clk);
  endtask

  task automatic send_random_point();
    longint span_xy, span_z;
    span_xy = coord_span(scale_ppm, longint'(CANVAS / 2) << lpbev_pkg::FRAC_W);
    span_z = coord_span(scale_inv_height, longint'(1) << lpbev_pkg::FRAC_W);
    send_point(pick_coord(span_xy), pick_coord(span_xy), pick_coord(span_z),
               lpbev_pkg::INTEN_W'($urandom));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (expected_writes.size() != 0);
  endtask

  task automatic write_reg(input logic [lpbev_pkg::CFG_IDX_W-1:0] idx,
                           input logic [lpbev_pkg::REG_W-1:0] data);
    wait_drained();
    cfg_index <= idx;
    cfg_data <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      lpbev_pkg::REG_PIXELS_PER_MM: scale_ppm = data;
      lpbev_pkg::REG_INV_HEIGHT:    scale_inv_height = data;
      default: ;
    endcase
    reg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_directed_points();
    send_point(0, 0, 0, 0);
    send_point(0, 0, 0, 255);
    send_point(0, 0, 131071, 255);
    send_point(0, 0, -131072, 0);
    send_point(0, 0, 1, 128);
    send_point(0, 0, -1, 128);
    send_point(0, 0, 500, 200);
    send_point(0, 0, 501, 200);
    send_point(-131072, 0, 0, 0);
    send_point(131071, 0, 0, 0);
    send_point(0, -131072, 0, 0);
    send_point(0, 131071, 0, 0);
    send_point(8000, 8000, 100, 10);
    // slightly past the edge still truncates to pixel zero
    send_point(8050, 8050, -100, 90);
    send_point(8051, 0, 50, 1);
    send_point(0, 8051, 50, 1);
    send_point(-8000, -8000, -100, 77);
    send_point(-8001, 0, 7, 3);
    send_point(0, -8001, 7, 3);
    send_point(-131072, -131072, -131072, 255);
    send_point(131071, 131071, 131071, 255);
    send_point(1, -1, -500, 33);
  endtask

  task automatic test_unknown_register();
    write_reg(REG_UNMAPPED_2, random_scale());
    write_reg(REG_UNMAPPED_3, random_scale());
    for (int i = 0; i < 20; i++) send_random_point();
  endtask

  task automatic test_register_extremes();
    logic [lpbev_pkg::REG_W-1:0] ppm_set[5] = '{24'd1, 24'hFFFFFF, 24'd0, 24'hFFFFFF, 24'd1};
    logic [lpbev_pkg::REG_W-1:0] inv_set[5] = '{24'd1, 24'hFFFFFF, 24'd0, 24'd1, 24'hFFFFFF};
    for (int k = 0; k < 5; k++) begin
      write_reg(lpbev_pkg::REG_PIXELS_PER_MM, ppm_set[k]);
      write_reg(lpbev_pkg::REG_INV_HEIGHT, inv_set[k]);
      for (int i = 0; i < 40; i++) send_random_point();
    end
  endtask

  task automatic test_random_points();
    for (int k = 0; k < 7; k++) begin
      if (k == 0) begin
        write_reg(lpbev_pkg::REG_PIXELS_PER_MM, lpbev_pkg::PIXELS_PER_MM_RST);
        write_reg(lpbev_pkg::REG_INV_HEIGHT, lpbev_pkg::INV_HEIGHT_RST);
      end else begin
        write_reg(lpbev_pkg::REG_PIXELS_PER_MM, random_scale());
        write_reg(lpbev_pkg::REG_INV_HEIGHT, random_scale());
      end
      for (int i = 0; i < 150; i++) send_random_point();
    end
  endtask

  task automatic test_full_rate();
    idle_en = 1'b0;
    for (int i = 0; i < 150; i++) send_random_point();
    idle_en = 1'b1;
  endtask

  task automatic test_output_backpressure();
    hold_req = 1'b1;
    for (int i = 0; i < 150; i++) send_random_point();
  endtask

  // result side: random stalls, or one long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        out_ready <= !idle_en || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_writes.size() == 0) begin
        mismatches++;
        $display("%0t: pixel write with none expected, actual index %0d mask %0d",
                 $time, out_pixel_index, out_write_mask);
      end else begin
        next_write = expected_writes.pop_front();
        check_field("in_canvas", 32'(next_write.in_canvas), 32'(out_in_canvas));
        check_field("pixel_index", 32'(next_write.pixel_index), 32'(out_pixel_index));
        check_field("blue", 32'(next_write.blue), 32'(out_blue));
        check_field("green", 32'(next_write.green), 32'(out_green));
        check_field("red", 32'(next_write.red), 32'(out_red));
        check_field("write_mask", 32'(next_write.write_mask), 32'(out_write_mask));
        writes_checked++;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no request moved for %0d cycles, %0d writes outstanding",
               $time, quiet_cycles, expected_writes.size());
      $display("** lidar_point_bev_pixel_painter: FAILED **");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_x_mm = '0;
    in_y_mm = '0;
    in_z_mm = '0;
    in_intensity = '0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    idle_en = 1'b1;
    hold_req = 1'b0;
    quiet_cycles = 0;
    scale_ppm = lpbev_pkg::PIXELS_PER_MM_RST;
    scale_inv_height = lpbev_pkg::INV_HEIGHT_RST;
    repeat (RST_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    test_directed_points();
    test_unknown_register();
    test_register_extremes();
    test_random_points();
    test_full_rate();
    test_output_backpressure();

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("%0d points sent, %0d pixel writes checked, %0d register writes",
             points_sent, writes_checked, reg_writes);
    $display("canvas edges, height clamps, zero and full-scale scales, full rate, long stall");
    if (mismatches == 0 && expected_writes.size() == 0) begin
      $display("** lidar_point_bev_pixel_painter: PASSED **");
    end else begin
      $display("%0d mismatches, %0d writes never seen", mismatches, expected_writes.size());
      $display("** lidar_point_bev_pixel_painter: FAILED **");
    end
    $finish;
  end

endmodule
